// ----- sv/rrts_pkg.sv -----
package rrts_pkg;

    localparam int THREADS_DEF = 16;

    localparam logic [7:0] MAIN_PRIO = 8'd31;

    localparam logic [1:0] REQ_START    = 2'd0;
    localparam logic [1:0] REQ_SCHEDULE = 2'd1;
    localparam logic [1:0] REQ_BLOCK    = 2'd2;
    localparam logic [1:0] REQ_UNBLOCK  = 2'd3;

    localparam logic [1:0] ERR_OK          = 2'd0;
    localparam logic [1:0] ERR_QUEUED      = 2'd1;
    localparam logic [1:0] ERR_EMPTY       = 2'd2;
    localparam logic [1:0] ERR_NOT_BLOCKED = 2'd3;

    localparam logic [1:0] BST_WAITING = 2'd1;
    localparam logic [1:0] BST_HANGING = 2'd2;

    typedef logic [2:0] t_status;

    localparam t_status ST_RUNNING = 3'd0;
    localparam t_status ST_READY   = 3'd1;
    localparam t_status ST_BLOCKED = 3'd2;
    localparam t_status ST_WAITING = 3'd3;
    localparam t_status ST_HANGING = 3'd4;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] thread_id;
        logic [7:0] priority_req;
        logic [1:0] block_status;
    } t_req;

    typedef struct packed {
        logic [3:0] running_id;
        logic       switched;
        logic [1:0] error;
        logic [4:0] ready_count;
    } t_res;

    typedef struct packed {
        t_status    status;
        logic [7:0] prio;
        logic [7:0] slice;
        logic       queued;
    } t_tcb;

    localparam t_tcb MAIN_TCB = '{status: ST_RUNNING, prio: MAIN_PRIO, slice: MAIN_PRIO,
                                  queued: 1'b0};
    localparam t_tcb IDLE_TCB = '{status: ST_BLOCKED, prio: 8'd0, slice: 8'd0,
                                  queued: 1'b0};

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_WB   = 3'b100
    } t_state;

endpackage

// ----- sv/rrts_stream_if.sv -----
interface rrts_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/round_robin_thread_scheduler_top.sv -----
// Channel   Dir  Payload                                              Transfer
// i_req     in   req_type, thread_id, priority_req, block_status      valid && ready
// o_res     out  running_id, switched, error, ready_count             valid && ready
//
// One request at a time: start, unblock and failed requests pass through S_IDLE and S_EXEC;
// a schedule or block that pops a thread other than the one first read also passes S_WB,
// because reads of the thread table are registered.
// Synchronous active-low reset; table entries return to reset values via valid bits.
// While o_res stalls, the next result parks in a skid slot and i_req holds off until it drains.
module round_robin_thread_scheduler_top
    import rrts_pkg::*;
#(
    parameter int THREADS = THREADS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rrts_stream_if.sink          i_req,
    rrts_stream_if.source        o_res
);

    localparam int IW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int CW = $clog2(THREADS + 1);
    localparam int SW = CW + 1;

    t_tcb            r_tbl_mem [THREADS];
    logic [IW-1:0]   r_rq_mem  [THREADS];
    logic [THREADS-1:0] r_vld;

    t_state          r_state, n_state;
    t_req            r_req;
    t_req            req_in;
    logic [IW-1:0]   r_a1;
    logic [IW-1:0]   r_next;
    logic [IW-1:0]   r_cur, n_cur;
    logic [IW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_cnt, n_cnt;

    t_tcb            r_tbl_q;
    logic            r_rd_vld;
    logic            r_rd_zero;
    logic [IW-1:0]   r_q_q;
    t_tcb            tbl_d;

    logic            accept;
    logic [IW-1:0]   tid_in_idx;
    logic [IW-1:0]   a1_in;
    logic            tid_ok;
    logic            cnt_full;
    logic [SW-1:0]   pos_sum;
    logic [IW-1:0]   tail_pos;
    logic [IW-1:0]   head_inc;
    logic [IW-1:0]   head_dec;
    logic [CW-1:0]   cnt_mid;
    t_status         blk_st;

    logic            base_wen;
    t_tcb            base_wdata;
    logic            pop;
    logic            merge;
    logic [IW-1:0]   nxt;
    logic [1:0]      err;
    logic            sw;

    logic            tbl_wen;
    logic [IW-1:0]   tbl_waddr;
    t_tcb            tbl_wdata;
    logic            tbl_ren;
    logic [IW-1:0]   tbl_raddr;
    logic            q_wen;
    logic [IW-1:0]   q_waddr;
    logic [IW-1:0]   q_wdata;

    logic            res_fire;
    t_res            res;
    logic            out_free;
    logic            r_out_vld;
    t_res            r_out;
    logic            r_pend;
    t_res            r_pend_data;

    assign req_in      = i_req.data;
    assign i_req.ready = (r_state == S_IDLE) && !r_pend;
    assign accept      = i_req.valid && i_req.ready;

    assign tid_in_idx  = IW'(req_in.thread_id);
    assign a1_in       = (req_in.req_type == REQ_START || req_in.req_type == REQ_UNBLOCK) ?
                         tid_in_idx : r_cur;

    assign tid_ok   = 32'(r_req.thread_id) < 32'(THREADS);
    assign cnt_full = r_cnt == CW'(THREADS);
    assign pos_sum  = SW'(r_head) + SW'(r_cnt);
    assign tail_pos = (pos_sum >= SW'(THREADS)) ? IW'(pos_sum - SW'(THREADS)) : IW'(pos_sum);
    assign head_inc = (r_head == IW'(THREADS - 1)) ? '0 : r_head + IW'(1);
    assign head_dec = (r_head == '0) ? IW'(THREADS - 1) : r_head - IW'(1);

    always_comb begin
        if (r_rd_vld) begin
            tbl_d = r_tbl_q;
        end else if (r_rd_zero) begin
            tbl_d = MAIN_TCB;
        end else begin
            tbl_d = IDLE_TCB;
        end
    end

    always_comb begin
        unique case (r_req.block_status)
            BST_WAITING: blk_st = ST_WAITING;
            BST_HANGING: blk_st = ST_HANGING;
            default:     blk_st = ST_BLOCKED;
        endcase
    end

    always_comb begin
        base_wen   = 1'b0;
        base_wdata = tbl_d;
        q_wen      = 1'b0;
        q_waddr    = tail_pos;
        q_wdata    = r_a1;
        n_head     = r_head;
        n_cnt      = r_cnt;
        cnt_mid    = r_cnt;
        pop        = 1'b0;
        nxt        = r_q_q;
        err        = ERR_OK;
        sw         = 1'b0;
        unique case (r_req.req_type)
            REQ_START: begin
                if (!tid_ok || tbl_d.queued || r_a1 == r_cur || cnt_full) begin
                    err = ERR_QUEUED;
                end else begin
                    base_wen   = 1'b1;
                    base_wdata = '{status: ST_READY, prio: r_req.priority_req,
                                   slice: r_req.priority_req, queued: 1'b1};
                    q_wen      = 1'b1;
                    n_cnt      = r_cnt + CW'(1);
                end
            end
            REQ_SCHEDULE: begin
                if (tbl_d.status == ST_RUNNING && !tbl_d.queued && !cnt_full) begin
                    base_wen   = 1'b1;
                    base_wdata = '{status: ST_READY, prio: tbl_d.prio, slice: tbl_d.prio,
                                   queued: 1'b1};
                    q_wen      = 1'b1;
                    cnt_mid    = r_cnt + CW'(1);
                end
                if (cnt_mid == '0) begin
                    err = ERR_EMPTY;
                end else begin
                    pop    = 1'b1;
                    sw     = 1'b1;
                    nxt    = (r_cnt == '0) ? r_cur : r_q_q;
                    n_head = head_inc;
                    n_cnt  = cnt_mid - CW'(1);
                end
            end
            REQ_BLOCK: begin
                if (r_cnt == '0) begin
                    err = ERR_EMPTY;
                end else begin
                    base_wen          = 1'b1;
                    base_wdata.status = blk_st;
                    pop               = 1'b1;
                    sw                = 1'b1;
                    n_head            = head_inc;
                    n_cnt             = r_cnt - CW'(1);
                end
            end
            REQ_UNBLOCK: begin
                if (!tid_ok || !(tbl_d.status == ST_BLOCKED || tbl_d.status == ST_WAITING ||
                                 tbl_d.status == ST_HANGING)) begin
                    err = ERR_NOT_BLOCKED;
                end else if (tbl_d.queued || cnt_full) begin
                    err = ERR_QUEUED;
                end else begin
                    base_wen          = 1'b1;
                    base_wdata.status = ST_READY;
                    base_wdata.queued = 1'b1;
                    q_wen             = 1'b1;
                    q_waddr           = head_dec;
                    n_head            = head_dec;
                    n_cnt             = r_cnt + CW'(1);
                end
            end
            default: begin
                err = ERR_OK;
            end
        endcase
    end

    assign merge = pop && (nxt == r_a1);
    assign n_cur = pop ? nxt : r_cur;

    always_comb begin
        tbl_wen   = 1'b0;
        tbl_waddr = r_a1;
        tbl_wdata = base_wdata;
        unique case (r_state)
            S_EXEC: begin
                tbl_wen = base_wen || merge;
                if (merge) begin
                    tbl_wdata = '{status: ST_RUNNING, prio: base_wdata.prio,
                                  slice: base_wdata.slice, queued: 1'b0};
                end
            end
            S_WB: begin
                tbl_wen   = 1'b1;
                tbl_waddr = r_next;
                tbl_wdata = '{status: ST_RUNNING, prio: tbl_d.prio, slice: tbl_d.slice,
                              queued: 1'b0};
            end
            default: begin
                tbl_wen = 1'b0;
            end
        endcase
    end

    assign tbl_ren   = accept || (r_state == S_EXEC && pop && !merge);
    assign tbl_raddr = (r_state == S_IDLE) ? a1_in : nxt;

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = accept ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = (pop && !merge) ? S_WB : S_IDLE;
            S_WB:    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign res_fire = r_state == S_EXEC;
    assign res      = '{running_id: 4'(n_cur), switched: sw, error: err,
                        ready_count: 5'(n_cnt)};
    assign out_free = !r_out_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (tbl_wen) begin
            r_tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_ren) begin
            r_tbl_q   <= r_tbl_mem[tbl_raddr];
            r_rd_vld  <= r_vld[tbl_raddr] && !(tbl_wen && tbl_waddr == tbl_raddr);
            r_rd_zero <= tbl_raddr == '0;
        end
        if (res_fire && q_wen) begin
            r_rq_mem[q_waddr] <= q_wdata;
        end
        if (accept) begin
            r_q_q <= r_rq_mem[r_head];
            r_req <= req_in;
            r_a1  <= a1_in;
        end
        if (res_fire) begin
            r_next <= nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_cur   <= '0;
            r_head  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (tbl_wen) begin
                r_vld[tbl_waddr] <= 1'b1;
            end
            if (res_fire) begin
                r_cur  <= n_cur;
                r_head <= n_head;
                r_cnt  <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
        end else if (out_free) begin
            if (res_fire) begin
                r_out_vld <= 1'b1;
            end else if (r_pend) begin
                r_out_vld <= 1'b1;
                r_pend    <= 1'b0;
            end else begin
                r_out_vld <= 1'b0;
            end
        end else if (res_fire) begin
            r_pend <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (res_fire) begin
                r_out <= res;
            end else if (r_pend) begin
                r_out <= r_pend_data;
            end
        end else if (res_fire) begin
            r_pend_data <= res;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

endmodule

// ----- dv/round_robin_thread_scheduler_top_test.sv -----
`timescale 1ns / 1ps

import rrts_pkg::*;

class sched_scoreboard;
    t_status    thr_status [THREADS_DEF];
    logic [7:0] thr_prio   [THREADS_DEF];
    logic [7:0] thr_slice  [THREADS_DEF];
    logic       thr_queued [THREADS_DEF];
    logic [3:0] ring       [THREADS_DEF];
    logic [3:0] ring_head;
    logic [4:0] ring_count;
    logic [3:0] running;
    t_res       expected_q [$];
    int         n_fail;

    function new();
        for (int t = 0; t < THREADS_DEF; t++) begin
            thr_status[t] = ST_BLOCKED;
            thr_prio[t]   = 8'd0;
            thr_slice[t]  = 8'd0;
            thr_queued[t] = 1'b0;
            ring[t]       = 4'd0;
        end
        thr_status[0] = ST_RUNNING;
        thr_prio[0]   = MAIN_PRIO;
        thr_slice[0]  = MAIN_PRIO;
        ring_head     = 4'd0;
        ring_count    = 5'd0;
        running       = 4'd0;
        n_fail        = 0;
    endfunction

    function void push_tail(logic [3:0] t);
        logic [3:0] pos;
        pos = ring_head + ring_count[3:0];
        ring[pos] = t;
        ring_count++;
        thr_queued[t] = 1'b1;
    endfunction

    function void run_next();
        logic [3:0] t;
        t = ring[ring_head];
        ring_head++;
        ring_count--;
        thr_queued[t] = 1'b0;
        thr_status[t] = ST_RUNNING;
        running = t;
    endfunction

    function void note_request(t_req r);
        t_res    want;
        t_status s;
        want.switched = 1'b0;
        want.error    = ERR_OK;
        case (r.req_type)
            REQ_START: begin
                if (thr_queued[r.thread_id] || r.thread_id == running ||
                    ring_count >= THREADS_DEF) begin
                    want.error = ERR_QUEUED;
                end else begin
                    thr_status[r.thread_id] = ST_READY;
                    thr_prio[r.thread_id]   = r.priority_req;
                    thr_slice[r.thread_id]  = r.priority_req;
                    push_tail(r.thread_id);
                end
            end
            REQ_SCHEDULE: begin
                if (thr_status[running] == ST_RUNNING && !thr_queued[running] &&
                    ring_count < THREADS_DEF) begin
                    push_tail(running);
                    thr_status[running] = ST_READY;
                    thr_slice[running]  = thr_prio[running];
                end
                if (ring_count == 0) begin
                    want.error = ERR_EMPTY;
                end else begin
                    run_next();
                    want.switched = 1'b1;
                end
            end
            REQ_BLOCK: begin
                if (ring_count == 0) begin
                    want.error = ERR_EMPTY;
                end else begin
                    if (r.block_status == BST_WAITING) s = ST_WAITING;
                    else if (r.block_status == BST_HANGING) s = ST_HANGING;
                    else s = ST_BLOCKED;
                    thr_status[running] = s;
                    run_next();
                    want.switched = 1'b1;
                end
            end
            default: begin
                s = thr_status[r.thread_id];
                if (s != ST_BLOCKED && s != ST_WAITING && s != ST_HANGING) begin
                    want.error = ERR_NOT_BLOCKED;
                end else if (thr_queued[r.thread_id] || ring_count >= THREADS_DEF) begin
                    want.error = ERR_QUEUED;
                end else begin
                    ring_head--;
                    ring[ring_head] = r.thread_id;
                    ring_count++;
                    thr_queued[r.thread_id] = 1'b1;
                    thr_status[r.thread_id] = ST_READY;
                end
            end
        endcase
        want.running_id  = running;
        want.ready_count = ring_count;
        expected_q.push_back(want);
    endfunction

    function void check_result(t_res got);
        t_res want;
        if (expected_q.size() == 0) begin
            n_fail++;
            if (n_fail <= 10)
                $display("unexpected result: running_id=%0d switched=%0d error=%0d count=%0d",
                         got.running_id, got.switched, got.error, got.ready_count);
            return;
        end
        want = expected_q.pop_front();
        if (got.running_id !== want.running_id || got.switched !== want.switched ||
            got.error !== want.error || got.ready_count !== want.ready_count) begin
            n_fail++;
            if (n_fail <= 10)
                $display({"bad result: expected running_id=%0d switched=%0d error=%0d count=%0d,",
                          " got running_id=%0d switched=%0d error=%0d count=%0d"},
                         want.running_id, want.switched, want.error, want.ready_count,
                         got.running_id, got.switched, got.error, got.ready_count);
        end
    endfunction
endclass

module round_robin_thread_scheduler_top_test;
    import rrts_pkg::*;

    localparam int N_RANDOM     = 1626;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rrts_stream_if #(.T(t_req)) req_if ();
    rrts_stream_if #(.T(t_res)) res_if ();

    round_robin_thread_scheduler_top #(
        .THREADS(THREADS_DEF)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    sched_scoreboard sb;
    int burst_left    = 0;
    int idle_cycles   = 0;
    int rx_mode       = 0;
    int rx_mode_left  = 0;
    int rx_stall_left = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_req make_req(logic [1:0] op, logic [3:0] tid, logic [7:0] prio,
                                      logic [1:0] bst);
        t_req r;
        r.req_type     = op;
        r.thread_id    = tid;
        r.priority_req = prio;
        r.block_status = bst;
        return r;
    endfunction

    task automatic issue(input t_req r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (rx_stall_left > 0) begin
            res_if.ready <= 1'b0;
            rx_stall_left--;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(20, 120);
            end
            rx_mode_left--;
            case (rx_mode)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    res_if.ready <= 1'b1;
                    if ($urandom_range(0, 9) == 0) rx_stall_left = $urandom_range(1, 12);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) sb.note_request(req_if.data);
            if (res_if.valid && res_if.ready) sb.check_result(res_if.data);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("round_robin_thread_scheduler_top: mismatch");
                $finish;
            end
        end
    end

    initial begin
        logic [1:0] op;
        logic [3:0] tid;
        logic [7:0] prio;
        logic [1:0] bst;
        int         kind;
        sb = new();
        req_if.valid = 1'b0;
        req_if.data  = '0;
        res_if.ready = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        issue(make_req(REQ_SCHEDULE, 4'd0, 8'd0, 2'd0));
        issue(make_req(REQ_BLOCK, 4'd0, 8'd0, 2'd0));
        issue(make_req(REQ_START, 4'd0, 8'd9, 2'd0));
        issue(make_req(REQ_UNBLOCK, 4'd0, 8'd0, 2'd0));
        issue(make_req(REQ_START, 4'd1, 8'h00, 2'd0));
        issue(make_req(REQ_START, 4'd1, 8'h40, 2'd0));
        issue(make_req(REQ_START, 4'd15, 8'hFF, 2'd3));
        issue(make_req(REQ_UNBLOCK, 4'd1, 8'hFF, 2'd0));
        issue(make_req(REQ_SCHEDULE, 4'd15, 8'd0, 2'd0));
        issue(make_req(REQ_BLOCK, 4'd0, 8'd0, BST_WAITING));
        issue(make_req(REQ_BLOCK, 4'd0, 8'd0, BST_HANGING));
        issue(make_req(REQ_BLOCK, 4'd0, 8'd0, 2'd3));
        issue(make_req(REQ_UNBLOCK, 4'd1, 8'd0, 2'd0));
        issue(make_req(REQ_UNBLOCK, 4'd15, 8'd0, 2'd0));
        issue(make_req(REQ_BLOCK, 4'd0, 8'd0, 2'd3));
        issue(make_req(REQ_UNBLOCK, 4'd0, 8'd0, 2'd0));
        for (int t = 2; t < 10; t++)
            issue(make_req(REQ_START, t[3:0], 8'($urandom_range(0, 255)), 2'd0));

        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 99);
            tid  = 4'($urandom_range(0, 15));
            bst  = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0)
                prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                prio = 8'($urandom_range(0, 255));
            if (kind < 25) begin
                op = REQ_START;
                if ($urandom_range(0, 3) != 0)
                    for (int k = 0; k < 8 && (sb.thr_queued[tid] || tid == sb.running); k++)
                        tid = 4'($urandom_range(0, 15));
            end else if (kind < 55) begin
                op = REQ_SCHEDULE;
            end else if (kind < 75) begin
                op = REQ_BLOCK;
            end else begin
                op = REQ_UNBLOCK;
                if ($urandom_range(0, 3) != 0)
                    for (int k = 0; k < 8 && (sb.thr_status[tid] == ST_RUNNING ||
                                              sb.thr_status[tid] == ST_READY); k++)
                        tid = 4'($urandom_range(0, 15));
            end
            issue(make_req(op, tid, prio, bst));
        end

        req_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.n_fail == 0 && sb.expected_q.size() == 0)
            $display("round_robin_thread_scheduler_top: match");
        else
            $display("round_robin_thread_scheduler_top: mismatch");
        $finish;
    end
endmodule
